[hdl/bpsd_pkg.sv]
`default_nettype none
package bpsd_pkg;

    // Largest accepted image, in pixels
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_W  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int AREA_W = 2 * DIM_W;

    localparam logic [31:0] HDR_LEN    = 32'd54;
    localparam logic [15:0] BMP_SIG    = 16'h4D42;
    localparam logic [15:0] BPP_24     = 16'd24;
    localparam logic [15:0] BPP_32     = 16'd32;
    localparam logic [7:0]  ALPHA_OPAQ = 8'hFF;
    localparam logic [31:0] AREA_LIMIT = 32'h3FFF_FFFF;

    // Header byte positions
    localparam logic [31:0] POS_SIG_LO = 32'd0;
    localparam logic [31:0] POS_SIG_HI = 32'd1;
    localparam logic [31:0] POS_OFF    = 32'd10;
    localparam logic [31:0] POS_WID    = 32'd18;
    localparam logic [31:0] POS_HGT    = 32'd22;
    localparam logic [31:0] POS_BPP    = 32'd28;
    localparam logic [31:0] POS_BPP_HI = 32'd29;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_TOO_SMALL,
        ERR_SIGNATURE,
        ERR_DEPTH,
        ERR_DIMENSIONS,
        ERR_BOUNDS,
        ERR_TOO_LARGE,
        ERR_OFFSET
    } err_t;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_PIXEL,
        OP_STATUS
    } op_t;

    // One queued work beat from the parser to the pixel packer
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [1:0]  chan;
        logic        is32;
        logic [23:0] index;
        logic        fin;
        err_t        code;
    } beat_t;

    // Bytes of padding that bring a row to a multiple of four
    function automatic logic [1:0] row_pad(input logic [1:0] w_lo, input logic is32);
        logic [1:0] rb;
        rb = is32 ? 2'd0 : 2'(w_lo + {w_lo, 1'b0});
        return 2'(2'd0 - rb);
    endfunction

endpackage
`default_nettype wire

[hdl/bpsd_if.sv]
`default_nettype none
interface bpsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       first_byte;

    modport source (output valid, output file_byte, output first_byte, input ready);
    modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

interface bpsd_out_if;
    logic        valid;
    logic        ready;
    logic        pixel_valid;
    logic [23:0] pixel_index;
    logic [31:0] color;
    logic        finished;
    logic [2:0]  error_code;

    modport source (output valid, output pixel_valid, output pixel_index, output color,
                    output finished, output error_code, input ready);
    modport sink   (input valid, input pixel_valid, input pixel_index, input color,
                    input finished, input error_code, output ready);
endinterface
`default_nettype wire

[hdl/bmp_pixel_stream_decoder.sv]
`default_nettype none
// Streaming decoder for uncompressed 24- and 32-bit BMP files. Bytes of one
// file enter in order on byte_in, one beat per cycle while ready is high;
// first_byte restarts the parse. Write file_size before the file starts. The
// 54-byte header is checked on its last byte; a failing header, or a file_size
// below 54, gives a single status beat with finished set and the error code.
// Each pixel then comes out as 0xAARRGGBB with its frame-buffer index (rows
// flipped unless the height is negative); the last pixel carries finished. The
// parser feeds a two-beat queue into the pixel packer, whose output register
// decouples the sink. The payload size check runs in a radix-4 multiply after
// byte 29, which the remaining header bytes cover.
module bmp_pixel_stream_decoder
    import bpsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    bpsd_in_if.sink          byte_in,
    bpsd_out_if.source       pixel_out
);

    beat_t wr_beat;
    beat_t rd_beat;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    bpsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_in     (byte_in),
        .push        (push),
        .wr_beat     (wr_beat),
        .full        (full)
    );

    bpsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_beat (wr_beat),
        .full    (full),
        .pop     (pop),
        .rd_beat (rd_beat),
        .empty   (empty)
    );

    bpsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_beat   (rd_beat),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out)
    );

endmodule
`default_nettype wire

[hdl/bpsd_queue.sv]
`default_nettype none
module bpsd_queue
    import bpsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  beat_t      wr_beat,
    output logic       full,
    input  wire logic  pop,
    output beat_t      rd_beat,
    output logic       empty
);

    beat_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_beat = slot_reg[rd_ptr_reg];

    // Store beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_beat;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/bpsd_front.sv]
`default_nettype none
module bpsd_front
    import bpsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data,
    bpsd_in_if.sink           byte_in,
    output logic              push,
    output beat_t             wr_beat,
    input  wire logic         full
);

    logic [31:0] file_size_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [15:0] sig_reg, sig_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] wid_reg, wid_next;
    logic [31:0] hgt_reg, hgt_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]  chan_reg, chan_next;
    logic [1:0]  pad_reg, pad_next;
    logic [23:0] base_reg, base_next;

    // Size check sequencer
    logic [4:0]  step_reg;
    logic [34:0] stride_reg;
    logic [36:0] stride3_reg;
    logic [31:0] hdig_reg;
    logic [31:0] acc_reg;
    logic        sat_reg;
    logic [23:0] base0_reg;
    logic [AREA_W-1:0] area_reg;

    logic        fire;
    logic        seq_start;
    logic        is32;
    logic [31:0] hmag;
    logic [47:0] base0_prod;
    logic [36:0] addend;
    logic [37:0] acc_sum;

    assign byte_in.ready = ~full;
    assign fire          = byte_in.valid & ~full;
    assign is32          = (bpp_reg == BPP_32);
    assign hmag          = hgt_reg[31] ? (~hgt_reg + 32'd1) : hgt_reg;
    assign base0_prod    = (hmag[23:0] - 24'd1) * wid_reg[23:0];

    // Register the file size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            file_size_reg <= cfg_wr_data;
        end
    end

    // Register the products needed by the header checks
    always_ff @(posedge clk)
    begin
        base0_reg <= base0_prod[23:0];
        area_reg  <= wid_reg[DIM_W-1:0] * hmag[DIM_W-1:0];
    end

    // Select the next radix-4 partial product of stride times height
    always_comb
    begin
        unique case (hdig_reg[31:30])
            2'd0:    addend = 37'd0;
            2'd1:    addend = 37'(stride_reg);
            2'd2:    addend = {1'b0, stride_reg, 1'b0};
            default: addend = stride3_reg;
        endcase
        acc_sum = 38'({acc_reg, 2'b00}) + 38'(addend);
    end

    // Accumulate padded pixel bytes, saturating above 32 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 5'd0;
        end
        else if (step_reg == 5'd0)
        begin
            if (seq_start)
            begin
                step_reg <= 5'd1;
            end
        end
        else if (step_reg == 5'd18)
        begin
            step_reg <= 5'd0;
        end
        else
        begin
            step_reg <= step_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == 5'd1)
        begin
            stride_reg <= is32 ? {1'b0, wid_reg, 2'b00}
                               : 35'({wid_reg, 1'b0}) + 35'(wid_reg)
                                 + 35'(row_pad(wid_reg[1:0], 1'b0));
            hdig_reg   <= hmag;
            acc_reg    <= 32'd0;
            sat_reg    <= 1'b0;
        end
        else if (step_reg == 5'd2)
        begin
            stride3_reg <= 37'({stride_reg, 1'b0}) + 37'(stride_reg);
        end
        else if (step_reg != 5'd0)
        begin
            hdig_reg <= {hdig_reg[29:0], 2'b00};
            if (sat_reg || (acc_sum[37:32] != 6'd0))
            begin
                sat_reg <= 1'b1;
            end
            else
            begin
                acc_reg <= acc_sum[31:0];
            end
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 32'd0;
            sig_reg   <= 16'd0;
            off_reg   <= 32'd0;
            wid_reg   <= 32'd0;
            hgt_reg   <= 32'd0;
            bpp_reg   <= 16'd0;
            col_reg   <= '0;
            row_reg   <= '0;
            chan_reg  <= 2'd0;
            pad_reg   <= 2'd0;
            base_reg  <= 24'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sig_reg   <= sig_next;
            off_reg   <= off_next;
            wid_reg   <= wid_next;
            hgt_reg   <= hgt_next;
            bpp_reg   <= bpp_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            chan_reg  <= chan_next;
            pad_reg   <= pad_next;
            base_reg  <= base_next;
        end
    end

    // Classify each byte beat and update the parse
    always_comb
    begin
        phase_t           ph;
        logic [31:0]      pos;
        logic [1:0]       idx;
        logic [1:0]       chan;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             do_pixel;
        logic [1:0]       last_chan;
        logic [1:0]       pad;
        err_t             code;
        logic [7:0]       b;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        sig_next   = sig_reg;
        off_next   = off_reg;
        wid_next   = wid_reg;
        hgt_next   = hgt_reg;
        bpp_next   = bpp_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        chan_next  = chan_reg;
        pad_next   = pad_reg;
        base_next  = base_reg;
        push       = 1'b0;
        seq_start  = 1'b0;
        wr_beat    = '0;
        do_pixel   = 1'b0;
        code       = ERR_NONE;
        b          = byte_in.file_byte;
        ph         = byte_in.first_byte ? PH_HEADER : phase_reg;
        pos        = byte_in.first_byte ? 32'd0 : pos_reg;
        chan       = byte_in.first_byte ? 2'd0 : chan_reg;
        col        = byte_in.first_byte ? '0 : col_reg;
        row        = byte_in.first_byte ? '0 : row_reg;
        idx        = 2'(pos[1:0] - 2'd2);
        last_chan  = is32 ? 2'd3 : 2'd2;
        pad        = row_pad(wid_reg[1:0], is32);

        if (fire)
        begin
            // Restart the parse on a new file
            if (byte_in.first_byte)
            begin
                phase_next = PH_HEADER;
                chan_next  = 2'd0;
                col_next   = '0;
                row_next   = '0;
                pad_next   = 2'd0;
                base_next  = 24'd0;
                pos_next   = 32'd0;
            end
            if (ph != PH_DONE)
            begin
                pos_next = pos + 32'd1;
                unique case (ph)
                    PH_HEADER:
                    begin
                        if (pos == 32'd0 && file_size_reg < HDR_LEN)
                        begin
                            phase_next   = PH_DONE;
                            push         = 1'b1;
                            wr_beat.op   = OP_STATUS;
                            wr_beat.fin  = 1'b1;
                            wr_beat.code = ERR_TOO_SMALL;
                        end
                        else
                        begin
                            // Capture header fields, little-endian
                            if (pos == POS_SIG_LO)
                            begin
                                sig_next[7:0] = b;
                            end
                            else if (pos == POS_SIG_HI)
                            begin
                                sig_next[15:8] = b;
                            end
                            else if (pos >= POS_OFF && pos < POS_OFF + 32'd4)
                            begin
                                off_next[8*idx +: 8] = b;
                            end
                            else if (pos >= POS_WID && pos < POS_WID + 32'd4)
                            begin
                                wid_next[8*idx +: 8] = b;
                            end
                            else if (pos >= POS_HGT && pos < POS_HGT + 32'd4)
                            begin
                                hgt_next[8*idx +: 8] = b;
                            end
                            else if (pos == POS_BPP)
                            begin
                                bpp_next[7:0] = b;
                            end
                            else if (pos == POS_BPP_HI)
                            begin
                                bpp_next[15:8] = b;
                                seq_start      = 1'b1;
                            end

                            // Validate on the last header byte
                            if (pos == HDR_LEN - 32'd1)
                            begin
                                priority if (sig_reg != BMP_SIG)
                                    code = ERR_SIGNATURE;
                                else if (bpp_reg != BPP_24 && bpp_reg != BPP_32)
                                    code = ERR_DEPTH;
                                else if (wid_reg[31] || wid_reg == 32'd0 || hgt_reg == 32'd0)
                                    code = ERR_DIMENSIONS;
                                else if (off_reg >= file_size_reg || sat_reg
                                         || acc_reg > file_size_reg - off_reg)
                                    code = ERR_BOUNDS;
                                else if (wid_reg > 32'(MAX_WIDTH) || hmag > 32'(MAX_HEIGHT)
                                         || 64'(area_reg) > 64'(AREA_LIMIT))
                                    code = ERR_TOO_LARGE;
                                else if (off_reg < HDR_LEN)
                                    code = ERR_OFFSET;
                                else
                                    code = ERR_NONE;

                                if (code != ERR_NONE)
                                begin
                                    phase_next   = PH_DONE;
                                    push         = 1'b1;
                                    wr_beat.op   = OP_STATUS;
                                    wr_beat.fin  = 1'b1;
                                    wr_beat.code = code;
                                end
                                else
                                begin
                                    phase_next = (off_reg == HDR_LEN) ? PH_PIXEL : PH_SKIP;
                                    base_next  = hgt_reg[31] ? 24'd0 : base0_reg;
                                end
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        if (pos == off_reg)
                        begin
                            do_pixel   = 1'b1;
                            phase_next = PH_PIXEL;
                        end
                    end
                    PH_PAD:
                    begin
                        pad_next = pad_reg - 2'd1;
                        if (pad_reg == 2'd1)
                        begin
                            phase_next = PH_PIXEL;
                        end
                    end
                    PH_PIXEL:
                    begin
                        do_pixel = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                // Hand channel bytes and pixel ends to the packer
                if (do_pixel)
                begin
                    push         = 1'b1;
                    wr_beat.data = b;
                    wr_beat.chan = chan;
                    wr_beat.is32 = is32;
                    if (chan < last_chan)
                    begin
                        wr_beat.op = OP_BYTE;
                        chan_next  = chan + 2'd1;
                    end
                    else
                    begin
                        wr_beat.op    = OP_PIXEL;
                        wr_beat.index = base_reg + 24'(col);
                        chan_next     = 2'd0;
                        if (32'(col) + 32'd1 >= wid_reg)
                        begin
                            col_next = '0;
                            if (32'(row) + 32'd1 >= hmag)
                            begin
                                phase_next  = PH_DONE;
                                wr_beat.fin = 1'b1;
                            end
                            else
                            begin
                                row_next  = row + 1'b1;
                                base_next = hgt_reg[31] ? base_reg + wid_reg[23:0]
                                                        : base_reg - wid_reg[23:0];
                                pad_next  = pad;
                                if (pad != 2'd0)
                                begin
                                    phase_next = PH_PAD;
                                end
                            end
                        end
                        else
                        begin
                            col_next = col + 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[hdl/bpsd_back.sv]
`default_nettype none
module bpsd_back
    import bpsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  beat_t      rd_beat,
    input  wire logic  empty,
    output logic       pop,
    bpsd_out_if.source pixel_out
);

    logic        ovalid_reg;
    logic        pv_reg;
    logic [23:0] index_reg;
    logic [31:0] color_reg;
    logic        fin_reg;
    err_t        code_reg;
    logic [23:0] partial_reg;

    logic        load_ok;
    logic        load;
    logic [31:0] color_next;

    assign load_ok = ~ovalid_reg | pixel_out.ready;
    assign pop     = ~empty & ((rd_beat.op == OP_BYTE) | load_ok);
    assign load    = pop & (rd_beat.op != OP_BYTE);

    // Pack the last channel byte with the collected ones
    always_comb
    begin
        if (rd_beat.is32)
        begin
            color_next = {rd_beat.data, partial_reg};
        end
        else
        begin
            color_next = {ALPHA_OPAQ, rd_beat.data, partial_reg[15:0]};
        end
    end

    // Collect channel bytes
    always_ff @(posedge clk)
    begin
        if (pop && rd_beat.op == OP_BYTE)
        begin
            unique case (rd_beat.chan)
                2'd0:    partial_reg[7:0]   <= rd_beat.data;
                2'd1:    partial_reg[15:8]  <= rd_beat.data;
                default: partial_reg[23:16] <= rd_beat.data;
            endcase
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (pixel_out.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (rd_beat.op == OP_PIXEL)
            begin
                pv_reg    <= 1'b1;
                index_reg <= rd_beat.index;
                color_reg <= color_next;
                fin_reg   <= rd_beat.fin;
                code_reg  <= ERR_NONE;
            end
            else
            begin
                pv_reg    <= 1'b0;
                index_reg <= 24'd0;
                color_reg <= 32'd0;
                fin_reg   <= 1'b1;
                code_reg  <= rd_beat.code;
            end
        end
    end

    assign pixel_out.valid       = ovalid_reg;
    assign pixel_out.pixel_valid = pv_reg;
    assign pixel_out.pixel_index = index_reg;
    assign pixel_out.color       = color_reg;
    assign pixel_out.finished    = fin_reg;
    assign pixel_out.error_code  = code_reg;

endmodule
`default_nettype wire
